/* design/iapee_pkg.sv */
// Package for the IAP eeprom controller: register select codes, trigger keys,
// command codes and the structs passed between front end, queue and back end.
// Depends on nothing.
package iapee_pkg;

   // Register select codes on the bus side.
   localparam logic [2:0] SEL_DATA    = 3'd0;
   localparam logic [2:0] SEL_ADDR_HI = 3'd1;
   localparam logic [2:0] SEL_ADDR_LO = 3'd2;
   localparam logic [2:0] SEL_COMMAND = 3'd3;
   localparam logic [2:0] SEL_TRIGGER = 3'd4;
   localparam logic [2:0] SEL_CONTROL = 3'd5;

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   localparam logic [7:0] KEY_FIRST   = 8'h46;
   localparam logic [7:0] KEY_SECOND  = 8'hB9;
   localparam logic [7:0] CMD_READ    = 8'h01;
   localparam logic [7:0] CMD_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_ERASE   = 8'h03;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   localparam int ENABLE_BIT = 7;

   localparam logic [15:0] WINDOW_BASE_RESET = 16'h2000;

   typedef enum logic [1:0] {
      OP_READ,
      OP_PROGRAM,
      OP_ERASE
   } op_type;

   // One storage operation handed from the front end to the back end.
   typedef struct packed {
      op_type      op;
      logic [15:0] offset;
      logic [7:0]  data;
   } job_type;

   // Completion report from the back end.
   typedef struct packed {
      logic       done;
      logic       is_read;
      logic [7:0] rdata;
   } done_type;

endpackage

/* design/iap_eeprom_controller_unit.sv */
// Top level of the IAP eeprom controller: front end, job queue and back end.
// Depends on iapee_pkg, iapee_front, iapee_queue and iapee_back.
//
// Usage: a bus access (req_mode, req_reg_select, req_bus_data) is taken at a
// rising clock edge where start is high and busy is low. Exactly one result
// follows on the next cycle: rsp_valid is high for one cycle with
// rsp_read_data, rsp_command_ran and rsp_command_error. The receiver cannot
// stall the result, so nothing waits on the output side.
// Plain register accesses leave busy low, so while busy is low one access
// can be accepted every cycle. A trigger write that starts a storage command
// raises busy while the back end works: a byte read or program goes through
// read, registered data and write back, and a sector erase first searches
// sector by sector for the target sector and then erases its bytes one by one.
// After reset busy stays high while the byte store is
// swept to the erased value 0xFF; csr_write_enable/csr_write_data load the
// window base at any time and should change only while the block is idle.
module iap_eeprom_controller_unit #(
   parameter int STORE_BYTES  = 4096,
   parameter int SECTOR_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [2:0]  req_reg_select,
   input  logic [7:0]  req_bus_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_command_ran,
   output logic        rsp_command_error,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic                back_idle;
   logic                job_push;
   logic                job_pop;
   logic                queue_empty;
   iapee_pkg::job_type  job_in;
   iapee_pkg::job_type  head_job;
   iapee_pkg::done_type done_info;

   iapee_front #(
      .STORE_BYTES(STORE_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_reg_select    (req_reg_select),
      .req_bus_data      (req_bus_data),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_command_ran   (rsp_command_ran),
      .rsp_command_error (rsp_command_error),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .back_idle         (back_idle),
      .done_info         (done_info),
      .job_push          (job_push),
      .job_out           (job_in)
   );

   iapee_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   iapee_back #(
      .STORE_BYTES (STORE_BYTES),
      .SECTOR_BYTES(SECTOR_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (job_pop),
      .idle        (back_idle),
      .done_info   (done_info)
   );

endmodule

/* design/iapee_front.sv */
// Front end of the IAP eeprom controller: bus register file, trigger key
// sequence, command classification and the registered result outputs.
// Depends on iapee_pkg.
module iapee_front #(
   parameter int STORE_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [2:0]         req_reg_select,
   input  logic [7:0]         req_bus_data,
   output logic               rsp_valid,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_command_ran,
   output logic               rsp_command_error,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               back_idle,
   input  iapee_pkg::done_type done_info,
   output logic               job_push,
   output iapee_pkg::job_type job_out
);

   localparam logic [16:0] STORE_LIMIT = 17'(STORE_BYTES);

   logic [15:0] window_base_ff;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  addr_hi_ff, addr_hi_in;
   logic [7:0]  addr_lo_ff, addr_lo_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  control_ff, control_in;
   logic        first_key_ff, first_key_in;
   logic        pending_ff, pending_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_ran_ff, rsp_ran_in;
   logic        rsp_error_ff, rsp_error_in;

   logic        accept;
   logic [15:0] offset;
   logic        in_window;
   logic        code_ok;
   iapee_pkg::op_type op_sel;

   assign busy   = pending_ff | ~back_idle;
   assign accept = start & ~busy;

   assign offset    = {addr_hi_ff, addr_lo_ff} - window_base_ff;
   assign in_window = {1'b0, offset} < STORE_LIMIT;
   assign code_ok   = (command_ff == iapee_pkg::CMD_READ) ||
                      (command_ff == iapee_pkg::CMD_PROGRAM) ||
                      (command_ff == iapee_pkg::CMD_ERASE);

   always_comb begin
      case (command_ff)
         iapee_pkg::CMD_READ:    op_sel = iapee_pkg::OP_READ;
         iapee_pkg::CMD_PROGRAM: op_sel = iapee_pkg::OP_PROGRAM;
         default:                op_sel = iapee_pkg::OP_ERASE;
      endcase
   end

   always_comb begin
      data_in          = data_ff;
      addr_hi_in       = addr_hi_ff;
      addr_lo_in       = addr_lo_ff;
      command_in       = command_ff;
      control_in       = control_ff;
      first_key_in     = first_key_ff;
      pending_in       = pending_ff;
      rsp_valid_in     = 1'b0;
      rsp_read_data_in = 8'h00;
      rsp_ran_in       = 1'b0;
      rsp_error_in     = 1'b0;
      job_push         = 1'b0;
      job_out.op       = op_sel;
      job_out.offset   = offset;
      job_out.data     = data_ff;

      // A finished read command lands in the data register.
      if (done_info.done) begin
         pending_in = 1'b0;
         if (done_info.is_read) begin
            data_in = done_info.rdata;
         end
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_mode == iapee_pkg::MODE_READ) begin
            case (req_reg_select)
               iapee_pkg::SEL_DATA:    rsp_read_data_in = data_ff;
               iapee_pkg::SEL_ADDR_HI: rsp_read_data_in = addr_hi_ff;
               iapee_pkg::SEL_ADDR_LO: rsp_read_data_in = addr_lo_ff;
               iapee_pkg::SEL_COMMAND: rsp_read_data_in = command_ff;
               iapee_pkg::SEL_CONTROL: rsp_read_data_in = control_ff;
               default:                rsp_read_data_in = 8'h00;
            endcase
         end else begin
            case (req_reg_select)
               iapee_pkg::SEL_DATA:    data_in    = req_bus_data;
               iapee_pkg::SEL_ADDR_HI: addr_hi_in = req_bus_data;
               iapee_pkg::SEL_ADDR_LO: addr_lo_in = req_bus_data;
               iapee_pkg::SEL_COMMAND: command_in = req_bus_data;
               iapee_pkg::SEL_CONTROL: control_in = req_bus_data;
               iapee_pkg::SEL_TRIGGER: begin
                  if (req_bus_data == iapee_pkg::KEY_FIRST) begin
                     first_key_in = 1'b1;
                  end else begin
                     first_key_in = 1'b0;
                     if (req_bus_data == iapee_pkg::KEY_SECOND && first_key_ff &&
                         control_ff[iapee_pkg::ENABLE_BIT]) begin
                        if (!code_ok || !in_window) begin
                           rsp_error_in = 1'b1;
                        end else begin
                           rsp_ran_in = 1'b1;
                           job_push   = 1'b1;
                           pending_in = 1'b1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff   <= iapee_pkg::WINDOW_BASE_RESET;
         data_ff          <= iapee_pkg::ERASED_BYTE;
         addr_hi_ff       <= 8'hFF;
         addr_lo_ff       <= 8'hFF;
         command_ff       <= 8'h00;
         control_ff       <= 8'h00;
         first_key_ff     <= 1'b0;
         pending_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_read_data_ff <= 8'h00;
         rsp_ran_ff       <= 1'b0;
         rsp_error_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_base_ff <= csr_write_data;
         end
         data_ff          <= data_in;
         addr_hi_ff       <= addr_hi_in;
         addr_lo_ff       <= addr_lo_in;
         command_ff       <= command_in;
         control_ff       <= control_in;
         first_key_ff     <= first_key_in;
         pending_ff       <= pending_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_ran_ff       <= rsp_ran_in;
         rsp_error_ff     <= rsp_error_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_command_ran   = rsp_ran_ff;
   assign rsp_command_error = rsp_error_ff;

endmodule

/* design/iapee_queue.sv */
// Two-entry job queue between the front end and the storage back end.
// Depends on iapee_pkg.
module iapee_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  iapee_pkg::job_type push_job,
   input  logic               pop,
   output logic               empty,
   output iapee_pkg::job_type head_job
);

   iapee_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign empty    = (count_ff == 2'd0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && (count_ff != 2'd2);
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/iapee_back.sv */
// Back end of the IAP eeprom controller: the byte store, its clearing pass
// after reset, and the read, program and sector erase sequencer.
// Depends on iapee_pkg.
module iapee_back #(
   parameter int STORE_BYTES  = 4096,
   parameter int SECTOR_BYTES = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  iapee_pkg::job_type  head_job,
   output logic                pop,
   output logic                idle,
   output iapee_pkg::done_type done_info
);

   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int EW = $clog2(STORE_BYTES + SECTOR_BYTES + 1);
   localparam logic [EW-1:0] STORE_END  = EW'(STORE_BYTES);
   localparam logic [EW-1:0] SECTOR_LEN = EW'(SECTOR_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_FINISH,
      ST_FIND,
      ST_ERASE
   } state_type;

   state_type          state_ff;
   iapee_pkg::op_type  op_ff;
   logic [AW-1:0]      addr_ff;
   logic [7:0]         wdata_ff;
   logic [EW-1:0]      idx_ff;
   logic [EW-1:0]      base_ff;
   logic               done_ff;
   logic               done_read_ff;
   logic [7:0]         done_data_ff;

   logic [7:0]         mem [STORE_BYTES];
   logic [7:0]         rd_data_ff;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [7:0]         mem_wdata;
   logic [EW-1:0]      sector_end;
   logic [EW-1:0]      erase_end;
   logic [EW-1:0]      offset_ext;

   assign idle       = (state_ff == ST_IDLE);
   assign pop        = idle && !queue_empty;
   assign sector_end = base_ff + SECTOR_LEN;
   assign erase_end  = (sector_end > STORE_END) ? STORE_END : sector_end;
   assign offset_ext = EW'(addr_ff);

   assign done_info.done    = done_ff;
   assign done_info.is_read = done_read_ff;
   assign done_info.rdata   = done_data_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = iapee_pkg::ERASED_BYTE;
      case (state_ff)
         ST_CLEAR, ST_ERASE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
         end
         ST_FINISH: begin
            if (op_ff == iapee_pkg::OP_PROGRAM) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & wdata_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         done_ff      <= 1'b0;
         done_read_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == STORE_END) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!queue_empty) begin
                  op_ff    <= head_job.op;
                  addr_ff  <= head_job.offset[AW-1:0];
                  wdata_ff <= head_job.data;
                  base_ff  <= '0;
                  if (head_job.op == iapee_pkg::OP_ERASE) begin
                     state_ff <= ST_FIND;
                  end else begin
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               // The read of the addressed byte is registered this cycle.
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               done_ff      <= 1'b1;
               done_read_ff <= (op_ff == iapee_pkg::OP_READ);
               done_data_ff <= rd_data_ff;
               state_ff     <= ST_IDLE;
            end
            ST_FIND: begin
               // Step sector by sector until the sector holding the offset is found.
               if (sector_end > offset_ext) begin
                  idx_ff   <= base_ff;
                  state_ff <= ST_ERASE;
               end else begin
                  base_ff <= sector_end;
               end
            end
            ST_ERASE: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == erase_end) begin
                  done_ff      <= 1'b1;
                  done_read_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
